[design/sem_pkg.sv]
package sem_pkg;

   localparam int PIXEL_WIDTH     = 8;
   localparam int CFG_WIDTH       = 11;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int GRAD_WIDTH      = 12;
   localparam int SQUARE_WIDTH    = 20;
   localparam int SUM_WIDTH       = 21;
   localparam int ROOT_WIDTH      = 11;
   localparam int ROOT_BITS       = 11;
   localparam int STEP_WIDTH      = 4;
   localparam int TAPS            = 9;
   localparam int CHANNELS        = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_HEIGHT = 8'd1;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] red_in;
      logic [PIXEL_WIDTH-1:0] green_in;
      logic [PIXEL_WIDTH-1:0] blue_in;
      logic                   flush;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] red_out;
      logic [PIXEL_WIDTH-1:0] green_out;
      logic [PIXEL_WIDTH-1:0] blue_out;
      logic                   end_of_frame;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_TAKE,
      OP_CONFIG,
      OP_ISSUE,
      OP_SQUARE,
      OP_SUM,
      OP_ROOT,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type             op;
      logic [STEP_WIDTH-1:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic out_busy;
   } dp_status_type;

endpackage

[design/sem_ctrl.sv]
module sem_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  sem_pkg::dp_status_type status,
   output sem_pkg::dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   logic [sem_pkg::STEP_WIDTH-1:0]   step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      cmd.op    = sem_pkg::OP_IDLE;
      cmd.step  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               cmd.op = sem_pkg::OP_CONFIG;
            end else if (req_valid) begin
               cmd.op = sem_pkg::OP_TAKE;
               if (status.emit) begin
                  state_in = ST_ISSUE;
                  step_in  = '0;
               end
            end
         end
         ST_ISSUE: begin
            cmd.op = sem_pkg::OP_ISSUE;
            if (step_ff == sem_pkg::STEP_WIDTH'(sem_pkg::TAPS - 1)) begin
               state_in = ST_DRAIN;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.op   = sem_pkg::OP_SQUARE;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = sem_pkg::OP_SUM;
            state_in = ST_ROOT;
            step_in  = '0;
         end
         ST_ROOT: begin
            cmd.op = sem_pkg::OP_ROOT;
            if (step_ff == sem_pkg::STEP_WIDTH'(sem_pkg::ROOT_BITS - 1)) begin
               state_in = ST_FINISH;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.op   = sem_pkg::OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[design/sem_datapath.sv]
module sem_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sem_pkg::dp_cmd_type                    cmd,
   output sem_pkg::dp_status_type                 status,
   input  sem_pkg::req_payload_type               req_data,
   input  logic [sem_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sem_pkg::CFG_WIDTH-1:0]          csr_data,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output sem_pkg::rsp_payload_type               rsp_data
);

   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int HIST = 2 * MAX_WIDTH + 3;
   localparam int AW   = $clog2(HIST);
   localparam int LW   = WW + 1;
   localparam int GW   = sem_pkg::GRAD_WIDTH;
   localparam int PW   = sem_pkg::PIXEL_WIDTH;
   localparam int RW   = sem_pkg::ROOT_WIDTH;
   localparam int SW   = sem_pkg::SUM_WIDTH;
   localparam int RESET_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
   localparam int RESET_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
   localparam logic signed [AW+1:0] HIST_S = (AW+2)'(HIST);
   localparam logic signed [AW+1:0] ONE_S  = (AW+2)'(1);

   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [HW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [WW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [LW-1:0] lag_ff, lag_in;
   logic [AW-1:0] wptr_ff, wptr_in, optr_ff, optr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [23:0]   hist_mem [HIST];
   logic [23:0]   rdata_ff;
   logic          issue_d_ff, inb_d_ff;
   logic [1:0]    dr_d_ff, dc_d_ff;

   logic signed [GW-1:0]             gx_ff [sem_pkg::CHANNELS];
   logic signed [GW-1:0]             gy_ff [sem_pkg::CHANNELS];
   logic [sem_pkg::SQUARE_WIDTH-1:0] sqx_ff [sem_pkg::CHANNELS];
   logic [sem_pkg::SQUARE_WIDTH-1:0] sqy_ff [sem_pkg::CHANNELS];
   logic [SW-1:0]                    sum_ff [sem_pkg::CHANNELS];
   logic [RW-1:0]                    root_ff [sem_pkg::CHANNELS];
   sem_pkg::rsp_payload_type         rsp_data_ff;

   logic          input_done, take_pixel, restart, last;
   int unsigned   cfg_val, clamp_w, clamp_h;
   logic [1:0]    dr, dc;
   logic          row_ok, col_ok;
   logic signed [AW+1:0] w_s, row_off, addr_sum;
   logic [AW-1:0] raddr;
   logic [RW-1:0] bit_mask;

   assign input_done = in_row_ff >= height_ff;
   assign take_pixel = (cmd.op == sem_pkg::OP_TAKE) && !req_data.flush && !input_done;
   assign last       = (out_row_ff == height_ff - 1'b1) && (out_col_ff == width_ff - 1'b1);

   assign status.emit     = (!req_data.flush && !input_done) ?
                            (lag_ff >= {1'b0, width_ff} + LW'(1)) : input_done;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      cfg_val = 32'(csr_data);
      clamp_w = (cfg_val == 0) ? 1 : ((cfg_val > MAX_WIDTH) ? MAX_WIDTH : cfg_val);
      clamp_h = (cfg_val == 0) ? 1 : ((cfg_val > MAX_HEIGHT) ? MAX_HEIGHT : cfg_val);
   end

   always_comb begin
      if (cmd.step < sem_pkg::STEP_WIDTH'(3)) begin
         dr = 2'd0;
         dc = 2'(cmd.step);
      end else if (cmd.step < sem_pkg::STEP_WIDTH'(6)) begin
         dr = 2'd1;
         dc = 2'(cmd.step - sem_pkg::STEP_WIDTH'(3));
      end else begin
         dr = 2'd2;
         dc = 2'(cmd.step - sem_pkg::STEP_WIDTH'(6));
      end
      row_ok = (dr == 2'd1) || ((dr == 2'd0) && (out_row_ff != '0)) ||
               ((dr == 2'd2) && (out_row_ff != height_ff - 1'b1));
      col_ok = (dc == 2'd1) || ((dc == 2'd0) && (out_col_ff != '0)) ||
               ((dc == 2'd2) && (out_col_ff != width_ff - 1'b1));
      w_s = $signed((AW+2)'(width_ff));
      case (dr)
         2'd0:    row_off = -w_s;
         2'd2:    row_off = w_s;
         default: row_off = '0;
      endcase
      addr_sum = $signed((AW+2)'(optr_ff)) + row_off + $signed((AW+2)'(dc)) - ONE_S;
      if (addr_sum < 0) begin
         addr_sum = addr_sum + HIST_S;
      end else if (addr_sum >= HIST_S) begin
         addr_sum = addr_sum - HIST_S;
      end
      raddr = AW'(addr_sum);
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      lag_in       = lag_ff;
      wptr_in      = wptr_ff;
      optr_in      = optr_ff;
      restart      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         sem_pkg::OP_CONFIG: begin
            if (csr_index == sem_pkg::CSR_FRAME_WIDTH) begin
               width_in = WW'(clamp_w);
               restart  = 1'b1;
            end else if (csr_index == sem_pkg::CSR_FRAME_HEIGHT) begin
               height_in = HW'(clamp_h);
               restart   = 1'b1;
            end
         end
         sem_pkg::OP_TAKE: begin
            if (take_pixel) begin
               wptr_in = (wptr_ff == AW'(HIST - 1)) ? '0 : wptr_ff + 1'b1;
               lag_in  = lag_ff + 1'b1;
               if (in_col_ff == width_ff - 1'b1) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + 1'b1;
               end else begin
                  in_col_in = in_col_ff + 1'b1;
               end
            end
         end
         sem_pkg::OP_FINISH: begin
            rsp_valid_in = 1'b1;
            if (last) begin
               restart = 1'b1;
            end else begin
               lag_in  = lag_ff - 1'b1;
               optr_in = (optr_ff == AW'(HIST - 1)) ? '0 : optr_ff + 1'b1;
               if (out_col_ff == width_ff - 1'b1) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 1'b1;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (restart) begin
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
         lag_in     = '0;
         wptr_in    = '0;
         optr_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WW'(RESET_W);
         height_ff    <= HW'(RESET_H);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         lag_ff       <= '0;
         wptr_ff      <= '0;
         optr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         issue_d_ff   <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         lag_ff       <= lag_in;
         wptr_ff      <= wptr_in;
         optr_ff      <= optr_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_d_ff   <= (cmd.op == sem_pkg::OP_ISSUE);
      end
   end

   always_ff @(posedge clock) begin
      if (take_pixel) begin
         hist_mem[wptr_ff] <= {req_data.blue_in, req_data.green_in, req_data.red_in};
      end
      if (cmd.op == sem_pkg::OP_ISSUE) begin
         rdata_ff <= hist_mem[raddr];
      end
   end

   assign bit_mask = RW'(1) << (sem_pkg::ROOT_BITS - 1 - int'(cmd.step));

   always_ff @(posedge clock) begin
      logic signed [GW-1:0]  v, v2;
      logic [RW-1:0]         t;
      logic [2*RW-1:0]       tsq, rr;
      logic [RW:0]           rounded;
      logic [PW-1:0]         sat [sem_pkg::CHANNELS];
      inb_d_ff <= row_ok && col_ok;
      dr_d_ff  <= dr;
      dc_d_ff  <= dc;
      for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
         v  = inb_d_ff ? $signed(GW'(rdata_ff[PW*ch +: PW])) : '0;
         v2 = v <<< 1;
         t  = root_ff[ch] | bit_mask;
         tsq = (2*RW)'(t) * (2*RW)'(t);
         rr  = (2*RW)'(root_ff[ch]) * (2*RW)'(root_ff[ch]) + (2*RW)'(root_ff[ch]);
         rounded = ((2*RW)'(sum_ff[ch]) > rr) ? {1'b0, root_ff[ch]} + 1'b1
                                               : {1'b0, root_ff[ch]};
         sat[ch] = (rounded > (RW+1)'(255)) ? PW'(255) : PW'(rounded);
         case (cmd.op)
            sem_pkg::OP_TAKE: begin
               gx_ff[ch] <= '0;
               gy_ff[ch] <= '0;
            end
            sem_pkg::OP_SQUARE: begin
               sqx_ff[ch] <= sem_pkg::SQUARE_WIDTH'(gx_ff[ch] * gx_ff[ch]);
               sqy_ff[ch] <= sem_pkg::SQUARE_WIDTH'(gy_ff[ch] * gy_ff[ch]);
            end
            sem_pkg::OP_SUM: begin
               sum_ff[ch]  <= SW'(sqx_ff[ch]) + SW'(sqy_ff[ch]);
               root_ff[ch] <= '0;
            end
            sem_pkg::OP_ROOT: begin
               if (tsq <= (2*RW)'(sum_ff[ch])) begin
                  root_ff[ch] <= t;
               end
            end
            default: begin
            end
         endcase
         if (issue_d_ff) begin
            case (dc_d_ff)
               2'd0:    gx_ff[ch] <= gx_ff[ch] - ((dr_d_ff == 2'd1) ? v2 : v);
               2'd2:    gx_ff[ch] <= gx_ff[ch] + ((dr_d_ff == 2'd1) ? v2 : v);
               default: gx_ff[ch] <= gx_ff[ch];
            endcase
            case (dr_d_ff)
               2'd0:    gy_ff[ch] <= gy_ff[ch] - ((dc_d_ff == 2'd1) ? v2 : v);
               2'd2:    gy_ff[ch] <= gy_ff[ch] + ((dc_d_ff == 2'd1) ? v2 : v);
               default: gy_ff[ch] <= gy_ff[ch];
            endcase
         end
      end
      if (cmd.op == sem_pkg::OP_FINISH) begin
         rsp_data_ff.red_out      <= sat[0];
         rsp_data_ff.green_out    <= sat[1];
         rsp_data_ff.blue_out     <= sat[2];
         rsp_data_ff.end_of_frame <= last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/sobel_edge_magnitude_rgb.sv]
// A pixel or flush that yields no result is taken in the idle state, which the block keeps.
// A request that yields a result occupies the block through nine line-memory reads
// (one port), gradient squaring and summing, and an 11-step square root per channel.
// The result is written to an output register when the root is done and waits there;
// a result still held there delays the next one until it is taken.
// Synchronous reset: frame size 640x480 (or the MAX sizes if smaller), position
// counters zero, output empty; line memory stays undefined, needing no clearing pass.
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sem_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sem_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sem_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sem_pkg::CFG_WIDTH-1:0]       csr_data
);

   sem_pkg::dp_cmd_type    cmd;
   sem_pkg::dp_status_type status;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sem_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
